// ----- rtl/rss_pkg.sv -----
// ray sphere shade package: internal Q3.12 widths, color factors, stage word type
// no dependencies; imported by the top level and the testbench
`timescale 1ns / 1ps

package rss_pkg;

  // internal fixed widths, all coordinates brought to Q3.12 first
  localparam int Q_W    = 16;   // direction component
  localparam int OC_W   = 17;   // center minus origin
  localparam int R_W    = 15;   // radius
  localparam int A_W    = 32;   // d.d
  localparam int H_W    = 34;   // d.oc, signed
  localparam int C_W    = 35;   // oc.oc - r*r, signed
  localparam int SQ_XW  = 66;   // sqrt operand
  localparam int SQ_RW  = SQ_XW / 2;
  localparam int LEN_W  = 17;   // floor(|d|)
  localparam int DEN_W  = 47;   // a * r
  localparam int NUM_W  = 48;   // channel numerator before scaling
  localparam int FAC_W  = 15;   // channel denominator factor

  // denominator factors of the three channel forms
  localparam logic [FAC_W-1:0] FAC_HIT = FAC_W'(2000);
  localparam logic [FAC_W-1:0] FAC_RED = FAC_W'(4000);
  localparam logic [FAC_W-1:0] FAC_GRN = FAC_W'(20000);

  // channel lanes
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_CEN_X = 3'd3,
    REG_CEN_Y = 3'd4,
    REG_CEN_Z = 3'd5,
    REG_RAD   = 3'd6
  } reg_idx_t;

  // ray word carried alongside the quadratic and the square root
  typedef struct packed {
    logic [2:0][Q_W-1:0]  d;
    logic [2:0][OC_W-1:0] oc;
    logic [A_W-1:0]       a;
    logic [H_W-1:0]       h;
    logic [R_W-1:0]       r;
    logic                 hit;
  } ray_t;

endpackage

// ----- rtl/ray_sphere_shade.sv -----
// ray sphere shade top level: quadratic, hit test, square root, shading divides
// depends on rss_pkg, rss_mul, rss_sqrt, rss_div
`timescale 1ns / 1ps
//
// Usage
//   A ray direction (dir_x, dir_y, dir_z) is taken at a rising edge with start high;
//   busy stays low, so a new ray may follow in every cycle.
//   The pixel (red, green, blue, hit) shows up for one cycle with done high,
//   once the ray has passed every pipeline stage; one pixel per cycle sustained.
//   The pipeline runs through the 33-stage square root and the COLOR_BITS-stage
//   dividers, plus the multiplier and shading stages around them.
//   The receiver cannot stall; results are simply presented in order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0..2 origin, 3..5 sphere center, 6 radius. Write only while
//   no ray is in flight.
//   Reset (rst, synchronous) empties the pipeline and sets origin 0, center
//   (0, 0, -1.0) and radius 0.5.
//   A hit gives 0.5 * (normal + 1) per channel; otherwise a white-to-blue gradient
//   on the direction's y component.

module ray_sphere_shade
  import rss_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int COLOR_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] dir_z,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  output logic                         done,
  output logic [COLOR_BITS-1:0]        red,
  output logic [COLOR_BITS-1:0]        green,
  output logic [COLOR_BITS-1:0]        blue,
  output logic                         hit
);

  localparam int SHR   = (COORD_BITS >= Q_W) ? COORD_BITS - Q_W : 0;
  localparam int SHL   = (COORD_BITS < Q_W) ? Q_W - COORD_BITS : 0;
  localparam int XTW   = COORD_BITS + Q_W;
  localparam int KS    = 1000 * (2 ** COLOR_BITS) - 1;
  localparam int KW    = $clog2(KS + 1);
  localparam int NW    = NUM_W + KW;
  localparam int DW    = DEN_W + FAC_W;
  localparam int LAT   = 44 + COLOR_BITS;
  localparam int SQ_V  = 5 + SQ_RW;
  localparam logic [COLOR_BITS-1:0] CMAX = '1;
  localparam logic [KW-1:0] KSCALE = KW'(KS);

  // signed coordinate to Q3.12, floor when narrowing
  function automatic logic [Q_W-1:0] to_q12(input logic signed [COORD_BITS-1:0] v);
    logic signed [XTW-1:0] w;
    w = XTW'(v);
    w = (w <<< SHL) >>> SHR;
    return w[Q_W-1:0];
  endfunction

  // unsigned radius to Q3.12
  function automatic logic [R_W-1:0] rad_q12(input logic [COORD_BITS-2:0] v);
    logic [XTW-1:0] w;
    w = XTW'(v);
    w = (w << SHL) >> SHR;
    return w[R_W-1:0];
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [2:0][COORD_BITS-1:0] org;
  logic [2:0][COORD_BITS-1:0] cen;
  logic [COORD_BITS-2:0]      rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      org <= '0;
      cen[0] <= '0;
      cen[1] <= '0;
      cen[2] <= COORD_BITS'(-(2 ** (COORD_BITS - 4)));
      rad <= (COORD_BITS-1)'(2 ** (COORD_BITS - 5));
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORG_X: org[0] <= cfg_data;
        REG_ORG_Y: org[1] <= cfg_data;
        REG_ORG_Z: org[2] <= cfg_data;
        REG_CEN_X: cen[0] <= cfg_data;
        REG_CEN_Y: cen[1] <= cfg_data;
        REG_CEN_Z: cen[2] <= cfg_data;
        REG_RAD:   rad    <= cfg_data[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  logic [LAT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start && !busy};
    end
  end

  assign done = vpipe[LAT-1];

  // stage 1: convert inputs, center minus origin
  logic [2:0][Q_W-1:0]  d1;
  logic [2:0][OC_W-1:0] oc1;
  logic [R_W-1:0]       r1;
  logic [2:0][Q_W-1:0]  din;

  assign din[0] = to_q12(dir_x);
  assign din[1] = to_q12(dir_y);
  assign din[2] = to_q12(dir_z);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1[i]  <= din[i];
      oc1[i] <= OC_W'($signed(to_q12(cen[i]))) - OC_W'($signed(to_q12(org[i])));
    end
    r1 <= rad_q12(rad);
  end

  // stage 2: component products
  logic [2:0][A_W-1:0]   dd2;
  logic [2:0][H_W-2:0]   dh2;
  logic [2:0][C_W-2:0]   cc2;
  logic [2*R_W-1:0]      rr2;
  logic [2:0][Q_W-1:0]   d2;
  logic [2:0][OC_W-1:0]  oc2;
  logic [R_W-1:0]        r2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd2[i] <= A_W'($signed(d1[i]) * $signed(d1[i]));
      dh2[i] <= (H_W-1)'($signed(d1[i]) * $signed(oc1[i]));
      cc2[i] <= (C_W-1)'($signed(oc1[i]) * $signed(oc1[i]));
    end
    rr2 <= r1 * r1;
    d2  <= d1;
    oc2 <= oc1;
    r2  <= r1;
  end

  // stage 3: a, h, c sums and the sign tests
  logic [A_W-1:0]        a_sum;
  logic signed [H_W-1:0] h_sum;
  logic signed [C_W-1:0] c_sum;
  logic signed [H_W-1:0] h3;
  logic signed [C_W-1:0] c3;
  ray_t                  ray3;

  assign a_sum = dd2[0] + dd2[1] + dd2[2];
  assign h_sum = H_W'($signed(dh2[0])) + H_W'($signed(dh2[1])) + H_W'($signed(dh2[2]));
  assign c_sum = C_W'($signed(cc2[0])) + C_W'($signed(cc2[1])) + C_W'($signed(cc2[2]))
               - $signed({5'b0, rr2});

  always_ff @(posedge clk) begin
    h3       <= h_sum;
    c3       <= c_sum;
    ray3.d   <= d2;
    ray3.oc  <= oc2;
    ray3.a   <= a_sum;
    ray3.h   <= h_sum;
    ray3.r   <= r2;
    ray3.hit <= (r2 != '0) && (a_sum != '0) && (c_sum > 0) && (h_sum > 0);
  end

  // stages 4 and 5: h*h and a*c
  logic signed [2*H_W-1:0]   hh5;
  logic signed [A_W+C_W:0]   ac5;
  ray_t                      ray4;
  ray_t                      ray5;

  rss_mul #(.WA(H_W), .WB(H_W)) u_mul_hh (
    .clk (clk),
    .a   (h3),
    .b   (h3),
    .p   (hh5)
  );

  rss_mul #(.WA(A_W + 1), .WB(C_W)) u_mul_ac (
    .clk (clk),
    .a   ($signed({1'b0, ray3.a})),
    .b   (c3),
    .p   (ac5)
  );

  always_ff @(posedge clk) begin
    ray4 <= ray3;
    ray5 <= ray4;
  end

  // stage 6: discriminant, hit, square root operand
  logic signed [2*H_W:0] disc;
  logic                  hit6;
  logic [SQ_XW-1:0]      sq_in;
  ray_t                  ray6;
  ray_t                  ray6_next;

  assign disc = (2*H_W+1)'(hh5) - (2*H_W+1)'(ac5);
  assign hit6 = ray5.hit && !disc[2*H_W];

  always_comb begin
    ray6_next     = ray5;
    ray6_next.hit = hit6;
  end

  always_ff @(posedge clk) begin
    sq_in <= hit6 ? disc[SQ_XW-1:0] : SQ_XW'(ray5.a);
    ray6  <= ray6_next;
  end

  // root of the discriminant on a hit, |d| otherwise
  logic [SQ_RW-1:0] sq_root;
  ray_t             sq_ray;

  rss_sqrt #(.XW(SQ_XW), .TW($bits(ray_t))) u_sqrt (
    .clk     (clk),
    .x       (sq_in),
    .tag_in  (ray6),
    .root    (sq_root),
    .tag_out (sq_ray)
  );

  // stage P: normal numerator products, a*r, gradient length
  logic signed [H_W:0]              hs;
  logic [2:0][H_W+Q_W:0]            nd_p;
  logic [2:0][A_W+OC_W:0]           ao_p;
  logic [DEN_W-1:0]                 den_p;
  logic [LEN_W-1:0]                 len_p;
  logic signed [Q_W-1:0]            dy_p;
  logic                             hit_p;

  assign hs = (H_W+1)'($signed(sq_ray.h)) - $signed({2'b0, sq_root});

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nd_p[i] <= hs * $signed(sq_ray.d[i]);
      ao_p[i] <= $signed({1'b0, sq_ray.a}) * $signed(sq_ray.oc[i]);
    end
    den_p <= DEN_W'(sq_ray.a * sq_ray.r);
    if (sq_root == '0) begin
      len_p <= LEN_W'(1);
      dy_p  <= '0;
    end else begin
      len_p <= sq_root[LEN_W-1:0];
      dy_p  <= $signed(sq_ray.d[1]);
    end
    hit_p <= sq_ray.hit;
  end

  // stage Q: clamp, pick numerator and denominator per channel
  logic signed [H_W+Q_W+1:0]  dens;
  logic signed [21:0]         l22;
  logic signed [21:0]         y22;
  logic signed [21:0]         num_red;
  logic signed [21:0]         num_grn;
  logic [2:0][NUM_W-1:0]      num_q;
  logic [2:0][FAC_W-1:0]      fac_q;
  logic [DEN_W-1:0]           dbase_q;
  logic                       hit_q;

  assign dens    = $signed({{(H_W+Q_W+2-DEN_W){1'b0}}, den_p});
  assign l22     = $signed({5'b0, len_p});
  assign y22     = 22'(dy_p);
  assign num_red = 3 * l22 - y22;
  assign num_grn = 17 * l22 - 3 * y22;

  for (genvar i = 0; i < 3; i++) begin : g_chan
    logic signed [H_W+Q_W+1:0] n_raw;
    logic signed [H_W+Q_W+1:0] n_clamp;
    logic signed [H_W+Q_W+1:0] n_sum;

    assign n_raw = (H_W+Q_W+2)'($signed(nd_p[i])) - (H_W+Q_W+2)'($signed(ao_p[i]));

    always_comb begin
      priority if (n_raw > dens) n_clamp = dens;
      else if (n_raw < -dens)   n_clamp = -dens;
      else                      n_clamp = n_raw;
    end

    assign n_sum = n_clamp + dens;

    always_ff @(posedge clk) begin
      if (hit_p) begin
        num_q[i] <= n_sum[NUM_W-1:0];
        fac_q[i] <= FAC_HIT;
      end else if (i == CH_R) begin
        num_q[i] <= NUM_W'(num_red);
        fac_q[i] <= FAC_RED;
      end else begin
        num_q[i] <= NUM_W'(num_grn);
        fac_q[i] <= FAC_GRN;
      end
    end
  end

  always_ff @(posedge clk) begin
    dbase_q <= hit_p ? den_p : DEN_W'(len_p);
    hit_q   <= hit_p;
  end

  // scaled numerator and denominator, then the divides
  logic [2:0][COLOR_BITS-1:0] q_ch;

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic signed [NUM_W+KW+1:0]  n_full;
    logic signed [DEN_W+FAC_W+1:0] d_full;

    rss_mul #(.WA(NUM_W + 1), .WB(KW + 1)) u_mul_n (
      .clk (clk),
      .a   ($signed({1'b0, num_q[i]})),
      .b   ($signed({1'b0, KSCALE})),
      .p   (n_full)
    );

    rss_mul #(.WA(DEN_W + 1), .WB(FAC_W + 1)) u_mul_d (
      .clk (clk),
      .a   ($signed({1'b0, dbase_q})),
      .b   ($signed({1'b0, fac_q[i]})),
      .p   (d_full)
    );

    rss_div #(.NW(NW), .DW(DW), .QW(COLOR_BITS)) u_div (
      .clk (clk),
      .n   (n_full[NW-1:0]),
      .d   (d_full[DW-1:0]),
      .q   (q_ch[i])
    );
  end

  // hit flag follows the multiply and divide stages
  logic [COLOR_BITS+1:0] hpipe;

  always_ff @(posedge clk) begin
    hpipe <= {hpipe[COLOR_BITS:0], hit_q};
  end

  // output word
  always_ff @(posedge clk) begin
    red   <= q_ch[CH_R];
    green <= q_ch[CH_G];
    blue  <= hpipe[COLOR_BITS+1] ? q_ch[CH_B] : CMAX;
    hit   <= hpipe[COLOR_BITS+1];
  end

  // background pixels are always full blue
  a_miss_blue: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> blue == CMAX)
    else $error("background pixel without full blue");

  // every pixel comes from an earlier ray taken with start high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("pixel without a matching ray");

  // the discriminant root never exceeds h on a hit
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    vpipe[SQ_V] && sq_ray.hit |-> {1'b0, sq_root} <= sq_ray.h)
    else $error("square root above h on a hit");

endmodule

// ----- rtl/rss_mul.sv -----
// two-stage signed multiplier: operand b split in halves, partial products registered
// depends on nothing but the clock
`timescale 1ns / 1ps

module rss_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                     clk,
  input  logic signed [WA-1:0]     a,
  input  logic signed [WB-1:0]     b,
  output logic signed [WA+WB-1:0]  p
);

  localparam int LO = WB / 2;
  localparam int HI = WB - LO;
  localparam int WP = WA + WB;

  logic signed [WA+LO:0]   p_lo;
  logic signed [WA+HI-1:0] p_hi;

  // partial products, then the shifted sum
  always_ff @(posedge clk) begin
    p_lo <= a * $signed({1'b0, b[LO-1:0]});
    p_hi <= a * $signed(b[WB-1:LO]);
    p    <= (WP'(p_hi) <<< LO) + WP'(p_lo);
  end

endmodule

// ----- rtl/rss_sqrt.sv -----
// pipelined integer square root, one root bit per stage, with a word carried along
// depends on nothing but the clock
`timescale 1ns / 1ps

module rss_sqrt #(
  parameter int XW = 66,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic [XW-1:0]   x,
  input  logic [TW-1:0]   tag_in,
  output logic [XW/2-1:0] root,
  output logic [TW-1:0]   tag_out
);

  localparam int RW = XW / 2;

  logic [XW-1:0] xs  [RW+1];
  logic [RW+1:0] rem [RW+1];
  logic [RW-1:0] rt  [RW+1];
  logic [TW-1:0] tg  [RW+1];

  assign xs[0]  = x;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign tg[0]  = tag_in;

  // one digit pair per stage
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rsh;
    logic [RW+1:0] trial;

    assign rsh   = {rem[k][RW-1:0], xs[k][2*(RW-1-k) +: 2]};
    assign trial = {rt[k], 2'b01};

    always_ff @(posedge clk) begin
      xs[k+1] <= xs[k];
      tg[k+1] <= tg[k];
      if (rsh >= trial) begin
        rem[k+1] <= rsh - trial;
        rt[k+1]  <= {rt[k][RW-2:0], 1'b1};
      end else begin
        rem[k+1] <= rsh;
        rt[k+1]  <= {rt[k][RW-2:0], 1'b0};
      end
    end
  end

  assign root    = rt[RW];
  assign tag_out = tg[RW];

endmodule

// ----- rtl/rss_div.sv -----
// pipelined restoring divider, one quotient bit per stage, quotient known to fit QW bits
// depends on nothing but the clock
`timescale 1ns / 1ps

module rss_div #(
  parameter int NW = 70,
  parameter int DW = 62,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] qs  [QW+1];

  assign rem[0] = n;
  assign dv[0]  = d;
  assign qs[0]  = '0;

  // most significant quotient bit first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW-1:0] sub;
    logic [CW-1:0] cur;

    assign sub = CW'(dv[k]) << (QW - 1 - k);
    assign cur = CW'(rem[k]);

    always_ff @(posedge clk) begin
      dv[k+1] <= dv[k];
      if (cur >= sub) begin
        rem[k+1] <= NW'(cur - sub);
        qs[k+1]  <= {qs[k][QW-2:0], 1'b1};
      end else begin
        rem[k+1] <= rem[k];
        qs[k+1]  <= {qs[k][QW-2:0], 1'b0};
      end
    end
  end

  assign q = qs[QW];

endmodule

// ----- tb/sv/tb_ray_sphere_shade.sv -----
// testbench for ray_sphere_shade: directed and random rays under several scene settings
// depends on rss_pkg and the ray_sphere_shade rtl; predicts each pixel exactly
`timescale 1ns / 1ps

module tb_ray_sphere_shade;
  import rss_pkg::*;

  localparam int  PIPE_DEPTH = 60;     // a little over the design's pipeline depth
  localparam int  STALL_MAX  = 3000;   // cycles with no handshake before giving up
  localparam int  RANDOM_PER = 220;
  localparam longint SHADE_K = 255999; // 1000 * 2^COLOR_BITS - 1

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       h;
  } pixel_t;

  // scene registers and the queue of predicted pixels
  class pixel_scoreboard;
    longint org[3];
    longint cen[3];
    longint rad;
    pixel_t pending[$];
    int     errors;

    function new();
      org = '{0, 0, 0};
      cen = '{0, 0, -4096};
      rad = 2048;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
      longint s;
      s = longint'($signed(v));
      if (idx == REG_RAD) rad = longint'(v[14:0]);
      else if (idx <= REG_ORG_Z) org[idx] = s;
      else cen[idx - REG_CEN_X] = s;
    endfunction

    // floor square root of a 128-bit value
    function logic [127:0] isqrt(logic [127:0] x);
      logic [127:0] res, t;
      res = 0;
      for (int i = 63; i >= 0; i--) begin
        t = res | (128'd1 << i);
        if (t * t <= x) res = t;
      end
      return res;
    endfunction

    // channel code: floor(prod / den) capped at full scale
    function logic [7:0] channel(logic [127:0] prod, logic [127:0] den);
      logic [127:0] q;
      q = prod / den;
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function pixel_t shade(longint d[3]);
      longint oc[3];
      longint a, h, c, den, n, len, dy;
      logic [127:0] hh, ac, root;
      pixel_t p;
      a = 0; h = 0; c = 0;
      for (int i = 0; i < 3; i++) begin
        oc[i] = cen[i] - org[i];
        a += d[i] * d[i];
        h += d[i] * oc[i];
        c += oc[i] * oc[i];
      end
      c -= rad * rad;
      hh = 128'(h) * 128'(h);
      ac = 128'(a) * 128'(c);
      if (rad > 0 && a > 0 && c > 0 && h > 0 && ac <= hh) begin
        // near root, unit normal scaled by a*r
        root = isqrt(hh - ac);
        den = a * rad;
        for (int i = 0; i < 3; i++) begin
          n = (h - longint'(root)) * d[i] - a * oc[i];
          if (n > den) n = den;
          if (n < -den) n = -den;
          if (i == 0) p.r = channel(128'(SHADE_K) * 128'(n + den), 128'(2000) * 128'(den));
          if (i == 1) p.g = channel(128'(SHADE_K) * 128'(n + den), 128'(2000) * 128'(den));
          if (i == 2) p.b = channel(128'(SHADE_K) * 128'(n + den), 128'(2000) * 128'(den));
        end
        p.h = 1'b1;
      end else begin
        // background gradient on the unit y component
        len = longint'(isqrt(128'(a)));
        dy = d[1];
        if (len == 0) begin
          len = 1;
          dy = 0;
        end
        p.r = channel(128'(SHADE_K) * 128'(3 * len - dy), 128'(4000) * 128'(len));
        p.g = channel(128'(SHADE_K) * 128'(17 * len - 3 * dy), 128'(20000) * 128'(len));
        p.b = 8'd255;
        p.h = 1'b0;
      end
      return p;
    endfunction

    function void note_ray(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      longint d[3];
      d[0] = longint'($signed(x));
      d[1] = longint'($signed(y));
      d[2] = longint'($signed(z));
      pending.push_back(shade(d));
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic h);
      pixel_t e;
      if (pending.size() == 0) begin
        $display("%0t: pixel with none predicted: got %0d %0d %0d hit %0b",
                 $realtime, r, g, b, h);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.r) begin
        $display("%0t: red expected %0d got %0d", $realtime, e.r, r);
        errors++;
      end
      if (g !== e.g) begin
        $display("%0t: green expected %0d got %0d", $realtime, e.g, g);
        errors++;
      end
      if (b !== e.b) begin
        $display("%0t: blue expected %0d got %0d", $realtime, e.b, b);
        errors++;
      end
      if (h !== e.h) begin
        $display("%0t: hit expected %0b got %0b", $realtime, e.h, h);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, hit;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic [7:0]  red, green, blue;

  pixel_scoreboard sb = new();
  int idle_cycles = 0;
  int gap_pct = 10;

  ray_sphere_shade uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .red(red), .green(green), .blue(blue),
    .hit(hit)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // monitor: note accepted rays, check pixels, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_ray(dir_x, dir_y, dir_z);
      if (done) sb.check_pixel(red, green, blue, hit);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // one ray word; the sender idles in about gap_pct cycles of a hundred
  task automatic send_ray(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    do @(posedge clk); while (busy);
  endtask

  // drain the pipeline before scene registers are written
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  task automatic write_scene(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                             logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                             logic [15:0] r);
    drain();
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_ORG_Z, oz);
    write_reg(REG_CEN_X, cx);
    write_reg(REG_CEN_Y, cy);
    write_reg(REG_CEN_Z, cz);
    write_reg(REG_RAD, r);
    cfg_valid <= 1'b0;
  endtask

  // random rays, each component mostly aimed near the sphere center so hits are common
  task automatic random_rays(int count);
    longint oc[3];
    logic [15:0] d[3];
    int sh;
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) gap_pct = 87;
      if (k == 2 * count / 3) gap_pct = 0;
      sh = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        oc[i] = sb.cen[i] - sb.org[i];
        if ($urandom_range(99) < 35) d[i] = 16'($urandom);
        else d[i] = 16'((oc[i] >>> (sh + 1)) + $signed(12'($urandom)) / 4);
      end
      if ($urandom_range(99) < 3) d = '{16'd0, 16'd0, 16'd0};
      send_ray(d[0], d[1], d[2]);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    dir_x = '0;
    dir_y = '0;
    dir_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: default scene, zero ray, straight hit, behind, extremes
    send_ray(16'd0, 16'd0, 16'd0);
    send_ray(16'd0, 16'd0, -16'sd4096);
    send_ray(16'd0, 16'd0, 16'd4096);
    send_ray(16'd0, 16'd1024, -16'sd4096);
    send_ray(16'd0, 16'd4096, 16'd0);
    send_ray(16'd0, -16'sd4096, 16'd0);
    send_ray(16'h7fff, 16'h7fff, 16'h7fff);
    send_ray(16'h8000, 16'h8000, 16'h8000);
    send_ray(16'h8000, 16'h7fff, 16'h8000);
    send_ray(16'd0, 16'h8000, 16'd0);
    send_ray(16'd0, 16'h7fff, 16'd0);
    send_ray(16'd1, 16'd0, 16'h8000);
    send_ray(16'd0, 16'd1, 16'd0);

    // tangent ray: discriminant exactly zero
    write_scene(16'd0, 16'd0, 16'd0, 16'd2048, 16'd0, -16'sd4096, 16'd2048);
    send_ray(16'd0, 16'd0, -16'sd4096);
    send_ray(16'd0, 16'd0, -16'sd1);
    // zero radius
    write_scene(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd4096, 16'd0);
    send_ray(16'd0, 16'd0, -16'sd4096);
    // origin at the center, inside the sphere
    write_scene(16'd100, 16'd200, 16'd300, 16'd100, 16'd200, 16'd300, 16'h7fff);
    send_ray(16'd0, 16'd0, -16'sd4096);
    send_ray(16'd4096, 16'd0, 16'd0);

    // random rays over several scenes, extremes among them
    gap_pct = 10;
    write_scene(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd4096, 16'd2048);
    random_rays(RANDOM_PER);
    gap_pct = 10;
    write_scene(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    random_rays(RANDOM_PER);
    gap_pct = 10;
    write_scene(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'd1);
    random_rays(RANDOM_PER);
    gap_pct = 10;
    write_scene(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 32767)));
    random_rays(RANDOM_PER);
    gap_pct = 10;
    write_scene(-16'sd2000, 16'd3000, 16'd8000, 16'd5000, -16'sd6000, -16'sd12000,
                16'($urandom_range(1000, 12000)));
    random_rays(RANDOM_PER);

    // wait out the pipeline
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
